@@ hdl/gdtq_pkg.sv @@
// ----------------------------------------------------------------------------
// gdtq_pkg
// Shared types and codes for the grouped deadline timer queue.
// ----------------------------------------------------------------------------
package gdtq_pkg;

  localparam int ENTRY_COUNT_DEF   = 64;
  localparam int GROUP_COUNT_DEF   = 8;
  localparam int DEADLINE_BITS_DEF = 32;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_ENTRY_FULL  = 2'd1;
  localparam logic [1:0] STATUS_GROUP_FULL  = 2'd2;
  localparam logic [1:0] STATUS_BAD_HANDLE  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_UNLINK,
    ST_RELINK,
    ST_SCAN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

endpackage

@@ hdl/gdtq_ram.sv @@
// ----------------------------------------------------------------------------
// gdtq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gdtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/gdtq_min_scan.sv @@
// ----------------------------------------------------------------------------
// gdtq_min_scan
// Shared compare unit: folds one group head per step into a running minimum.
// ----------------------------------------------------------------------------
module gdtq_min_scan #(
  parameter int DEADLINE_BITS = gdtq_pkg::DEADLINE_BITS_DEF,
  parameter int ENTRY_BITS    = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  gdtq_pkg::scan_ctl_t      ctl,
  input  logic                     el_valid,
  input  logic [DEADLINE_BITS-1:0] el_deadline,
  input  logic [ENTRY_BITS-1:0]    el_handle,
  input  logic [15:0]              el_client,
  output logic                     best_found,
  output logic [DEADLINE_BITS-1:0] best_deadline,
  output logic [ENTRY_BITS-1:0]    best_handle,
  output logic [15:0]              best_client
);

  logic                     found_r;
  logic [DEADLINE_BITS-1:0] dl_r;
  logic [ENTRY_BITS-1:0]    h_r;
  logic [15:0]              cli_r;
  logic                     take;

  assign take = ctl.step && el_valid && (!found_r || (el_deadline < dl_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.clear) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !ctl.clear) begin
      dl_r  <= el_deadline;
      h_r   <= el_handle;
      cli_r <= el_client;
    end
  end

  assign best_found    = found_r;
  assign best_deadline = dl_r;
  assign best_handle   = h_r;
  assign best_client   = cli_r;

endmodule

@@ hdl/grouped_deadline_timer_queue_top.sv @@
// ----------------------------------------------------------------------------
// grouped_deadline_timer_queue_top
// Deadline tracker with per-timeout-class FIFOs and an earliest-entry report.
// ----------------------------------------------------------------------------
// One item at a time. After the input transfer, an add or any rejected item
// goes from DECODE to SCAN; an update, or a remove that moves a class head,
// goes DECODE, UNLINK, RELINK, SCAN; any other remove goes DECODE, UNLINK,
// SCAN. SCAN is the minimum scan: one comparator visits each of the
// GROUP_COUNT cached class heads, one per cycle. Entry links and payload
// sit in RAMs with a registered read.
// in_ready is low from the input transfer until the result transfer completes.
module grouped_deadline_timer_queue_top #(
  parameter int ENTRY_COUNT   = gdtq_pkg::ENTRY_COUNT_DEF,
  parameter int GROUP_COUNT   = gdtq_pkg::GROUP_COUNT_DEF,
  parameter int DEADLINE_BITS = gdtq_pkg::DEADLINE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_timeout_value,
  input  logic [15:0] in_client_id,
  input  logic [31:0] in_deadline,
  input  logic [5:0]  in_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [5:0]  out_entry_handle,
  output logic        out_min_valid,
  output logic [5:0]  out_min_handle,
  output logic [15:0] out_min_client,
  output logic [31:0] out_min_deadline,
  output logic        out_is_empty
);

  localparam int EW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam int DW = DEADLINE_BITS + 16 + GW;

  gdtq_pkg::state_t state_r, state_nxt;

  logic [1:0]               kind_r;
  logic [15:0]              key_r;
  logic [15:0]              client_r, client_nxt;
  logic [DEADLINE_BITS-1:0] dl_r;
  logic [5:0]               h_r;

  logic [ENTRY_COUNT-1:0]   entry_used_r, entry_used_nxt;
  logic [GROUP_COUNT-1:0]   group_used_r, group_used_nxt;
  logic [15:0]              group_key_r  [GROUP_COUNT];
  logic [15:0]              group_key_nxt[GROUP_COUNT];
  logic [EW-1:0]            group_head_r  [GROUP_COUNT];
  logic [EW-1:0]            group_head_nxt[GROUP_COUNT];
  logic [EW-1:0]            group_tail_r  [GROUP_COUNT];
  logic [EW-1:0]            group_tail_nxt[GROUP_COUNT];
  logic [DEADLINE_BITS-1:0] group_hdl_r  [GROUP_COUNT];
  logic [DEADLINE_BITS-1:0] group_hdl_nxt[GROUP_COUNT];
  logic [15:0]              group_hcli_r  [GROUP_COUNT];
  logic [15:0]              group_hcli_nxt[GROUP_COUNT];

  logic [1:0]    status_r, status_nxt;
  logic [EW-1:0] op_handle_r, op_handle_nxt;
  logic [GW-1:0] op_group_r, op_group_nxt;
  logic          head_moved_r, head_moved_nxt;
  logic [GW-1:0] scan_idx_r, scan_idx_nxt;

  logic          data_we, next_we, prev_we;
  logic [EW-1:0] data_waddr, next_waddr, prev_waddr;
  logic [EW-1:0] data_raddr, link_raddr;
  logic [DW-1:0] data_wdata, data_rdata;
  logic [EW-1:0] next_wdata, prev_wdata, next_rdata, prev_rdata;

  logic [DEADLINE_BITS-1:0] rd_dl;
  logic [15:0]              rd_client;
  logic [GW-1:0]            rd_group;

  logic          free_e_ok, match_ok, free_g_ok;
  logic [EW-1:0] free_e;
  logic [GW-1:0] match_g, free_g;
  logic [EW-1:0] h_idx;
  logic          h_ok;

  gdtq_pkg::scan_ctl_t      scan_ctl;
  logic                     best_found;
  logic [DEADLINE_BITS-1:0] best_dl;
  logic [EW-1:0]            best_h;
  logic [15:0]              best_cli;

  logic in_xfer;

  assign in_ready = (state_r == gdtq_pkg::ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  assign rd_dl     = data_rdata[DW-1 -: DEADLINE_BITS];
  assign rd_client = data_rdata[GW +: 16];
  assign rd_group  = data_rdata[GW-1:0];

  assign h_idx = EW'(h_r);
  assign h_ok  = (32'(h_r) < ENTRY_COUNT) && entry_used_r[h_idx];

  always_comb begin
    free_e_ok = 1'b0;
    free_e    = '0;
    for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
      if (!entry_used_r[i]) begin
        free_e_ok = 1'b1;
        free_e    = EW'(i);
      end
    end
  end

  always_comb begin
    match_ok  = 1'b0;
    match_g   = '0;
    free_g_ok = 1'b0;
    free_g    = '0;
    for (int i = GROUP_COUNT - 1; i >= 0; i--) begin
      if (group_used_r[i] && (group_key_r[i] == key_r)) begin
        match_ok = 1'b1;
        match_g  = GW'(i);
      end
      if (!group_used_r[i]) begin
        free_g_ok = 1'b1;
        free_g    = GW'(i);
      end
    end
  end

  gdtq_ram #(.WIDTH(DW), .DEPTH(ENTRY_COUNT)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .raddr (data_raddr),
    .rdata (data_rdata)
  );

  gdtq_ram #(.WIDTH(EW), .DEPTH(ENTRY_COUNT)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (link_raddr),
    .rdata (next_rdata)
  );

  gdtq_ram #(.WIDTH(EW), .DEPTH(ENTRY_COUNT)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (link_raddr),
    .rdata (prev_rdata)
  );

  gdtq_min_scan #(.DEADLINE_BITS(DEADLINE_BITS), .ENTRY_BITS(EW)) u_min_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (scan_ctl),
    .el_valid      (group_used_r[scan_idx_r]),
    .el_deadline   (group_hdl_r[scan_idx_r]),
    .el_handle     (group_head_r[scan_idx_r]),
    .el_client     (group_hcli_r[scan_idx_r]),
    .best_found    (best_found),
    .best_deadline (best_dl),
    .best_handle   (best_h),
    .best_client   (best_cli)
  );

  always_comb begin
    logic [GW-1:0] g;
    logic [EW-1:0] nx;
    logic [EW-1:0] pv;
    logic          is_head;
    logic          is_tail;

    state_nxt      = state_r;
    entry_used_nxt = entry_used_r;
    group_used_nxt = group_used_r;
    group_key_nxt  = group_key_r;
    group_head_nxt = group_head_r;
    group_tail_nxt = group_tail_r;
    group_hdl_nxt  = group_hdl_r;
    group_hcli_nxt = group_hcli_r;
    status_nxt     = status_r;
    op_handle_nxt  = op_handle_r;
    op_group_nxt   = op_group_r;
    head_moved_nxt = head_moved_r;
    client_nxt     = client_r;
    scan_idx_nxt   = scan_idx_r;
    scan_ctl       = '0;

    data_we    = 1'b0;
    data_waddr = op_handle_r;
    data_wdata = {dl_r, client_r, op_group_r};
    data_raddr = op_handle_r;
    link_raddr = op_handle_r;
    next_we    = 1'b0;
    next_waddr = '0;
    next_wdata = '0;
    prev_we    = 1'b0;
    prev_waddr = '0;
    prev_wdata = '0;

    g       = rd_group;
    nx      = next_rdata;
    pv      = prev_rdata;
    is_head = 1'b0;
    is_tail = 1'b0;

    unique case (state_r)
      gdtq_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = gdtq_pkg::ST_DECODE;
        end
      end

      gdtq_pkg::ST_DECODE: begin
        scan_ctl.clear = 1'b1;
        scan_idx_nxt   = '0;
        status_nxt     = gdtq_pkg::STATUS_OK;
        head_moved_nxt = 1'b0;
        state_nxt      = gdtq_pkg::ST_SCAN;
        if (kind_r == gdtq_pkg::KIND_ADD) begin
          if (!free_e_ok) begin
            status_nxt = gdtq_pkg::STATUS_ENTRY_FULL;
          end else if (!match_ok && !free_g_ok) begin
            status_nxt = gdtq_pkg::STATUS_GROUP_FULL;
          end else begin
            g = match_ok ? match_g : free_g;
            if (!match_ok) begin
              group_key_nxt[g] = key_r;
            end
            op_handle_nxt          = free_e;
            entry_used_nxt[free_e] = 1'b1;
            data_we    = 1'b1;
            data_waddr = free_e;
            data_wdata = {dl_r, client_r, g};
            if (group_used_r[g]) begin
              next_we           = 1'b1;
              next_waddr        = group_tail_r[g];
              next_wdata        = free_e;
              prev_we           = 1'b1;
              prev_waddr        = free_e;
              prev_wdata        = group_tail_r[g];
              group_tail_nxt[g] = free_e;
            end else begin
              group_used_nxt[g] = 1'b1;
              group_head_nxt[g] = free_e;
              group_tail_nxt[g] = free_e;
              group_hdl_nxt[g]  = dl_r;
              group_hcli_nxt[g] = client_r;
            end
          end
        end else if ((kind_r == gdtq_pkg::KIND_UPDATE) ||
                     (kind_r == gdtq_pkg::KIND_REMOVE)) begin
          if (!h_ok) begin
            status_nxt = gdtq_pkg::STATUS_BAD_HANDLE;
          end else begin
            op_handle_nxt = h_idx;
            data_raddr    = h_idx;
            link_raddr    = h_idx;
            state_nxt     = gdtq_pkg::ST_UNLINK;
          end
        end else begin
          status_nxt = gdtq_pkg::STATUS_BAD_HANDLE;
        end
      end

      gdtq_pkg::ST_UNLINK: begin
        op_group_nxt = g;
        client_nxt   = rd_client;
        is_head      = (group_head_r[g] == op_handle_r);
        is_tail      = (group_tail_r[g] == op_handle_r);
        data_raddr   = nx;
        if (is_head && is_tail) begin
          group_used_nxt[g] = 1'b0;
        end else if (is_head) begin
          group_head_nxt[g] = nx;
          head_moved_nxt    = 1'b1;
        end else if (is_tail) begin
          group_tail_nxt[g] = pv;
        end else begin
          next_we    = 1'b1;
          next_waddr = pv;
          next_wdata = nx;
          prev_we    = 1'b1;
          prev_waddr = nx;
          prev_wdata = pv;
        end
        if (kind_r == gdtq_pkg::KIND_REMOVE) begin
          entry_used_nxt[op_handle_r] = 1'b0;
        end
        if ((kind_r == gdtq_pkg::KIND_UPDATE) || (is_head && !is_tail)) begin
          state_nxt = gdtq_pkg::ST_RELINK;
        end else begin
          state_nxt = gdtq_pkg::ST_SCAN;
        end
      end

      gdtq_pkg::ST_RELINK: begin
        g = op_group_r;
        if (head_moved_r) begin
          group_hdl_nxt[g]  = rd_dl;
          group_hcli_nxt[g] = rd_client;
        end
        if (kind_r == gdtq_pkg::KIND_UPDATE) begin
          data_we    = 1'b1;
          data_waddr = op_handle_r;
          data_wdata = {dl_r, client_r, g};
          if (group_used_r[g]) begin
            next_we           = 1'b1;
            next_waddr        = group_tail_r[g];
            next_wdata        = op_handle_r;
            prev_we           = 1'b1;
            prev_waddr        = op_handle_r;
            prev_wdata        = group_tail_r[g];
            group_tail_nxt[g] = op_handle_r;
          end else begin
            group_used_nxt[g] = 1'b1;
            group_head_nxt[g] = op_handle_r;
            group_tail_nxt[g] = op_handle_r;
            group_hdl_nxt[g]  = dl_r;
            group_hcli_nxt[g] = client_r;
          end
        end
        state_nxt = gdtq_pkg::ST_SCAN;
      end

      gdtq_pkg::ST_SCAN: begin
        scan_ctl.step = 1'b1;
        if (scan_idx_r == GW'(GROUP_COUNT - 1)) begin
          state_nxt = gdtq_pkg::ST_OUT;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end

      gdtq_pkg::ST_OUT: begin
        if (out_ready) begin
          state_nxt = gdtq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = gdtq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gdtq_pkg::ST_IDLE;
      entry_used_r <= '0;
      group_used_r <= '0;
    end else begin
      state_r      <= state_nxt;
      entry_used_r <= entry_used_nxt;
      group_used_r <= group_used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r <= in_kind;
      key_r  <= in_timeout_value;
      dl_r   <= DEADLINE_BITS'(in_deadline);
      h_r    <= in_handle;
    end
    client_r      <= in_xfer ? in_client_id : client_nxt;
    group_key_r   <= group_key_nxt;
    group_head_r  <= group_head_nxt;
    group_tail_r  <= group_tail_nxt;
    group_hdl_r   <= group_hdl_nxt;
    group_hcli_r  <= group_hcli_nxt;
    status_r      <= status_nxt;
    op_handle_r   <= op_handle_nxt;
    op_group_r    <= op_group_nxt;
    head_moved_r  <= head_moved_nxt;
    scan_idx_r    <= scan_idx_nxt;
  end

  assign out_valid        = (state_r == gdtq_pkg::ST_OUT);
  assign out_status       = status_r;
  assign out_entry_handle = (status_r == gdtq_pkg::STATUS_OK) ? 6'(op_handle_r) : 6'd0;
  assign out_min_valid    = best_found;
  assign out_min_handle   = best_found ? 6'(best_h) : 6'd0;
  assign out_min_client   = best_found ? best_cli : 16'd0;
  assign out_min_deadline = best_found ? 32'(best_dl) : 32'd0;
  assign out_is_empty     = !best_found;

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and result sides open together");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid)
    else $error("result presented right after input transfer");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_min_valid != out_is_empty))
    else $error("empty flag disagrees with min_valid");

  a_err_handle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != gdtq_pkg::STATUS_OK)) |-> (out_entry_handle == 6'd0))
    else $error("entry handle set on failed operation");
`endif

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Grouped deadline timer queue testbench
// Drives adds, updates and removes through the valid/ready input channel,
// predicts each result with a behavioral copy of the class FIFOs, and checks
// every output field. Directed rows first, then mostly well-formed random
// traffic with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int NE = 64;
  localparam int NG = 8;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] KIND_BAD = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] tmo;
    logic [15:0] client;
    logic [31:0] dl;
    logic [5:0]  handle;
  } timer_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  ehandle;
    logic        mvalid;
    logic [5:0]  mhandle;
    logic [15:0] mclient;
    logic [31:0] mdl;
    logic        empty;
  } timer_rsp_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] in_kind = '0;
  logic [15:0] in_timeout_value = '0;
  logic [15:0] in_client_id = '0;
  logic [31:0] in_deadline = '0;
  logic [5:0] in_handle = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] out_status;
  logic [5:0] out_entry_handle;
  logic out_min_valid;
  logic [5:0] out_min_handle;
  logic [15:0] out_min_client;
  logic [31:0] out_min_deadline;
  logic out_is_empty;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  grouped_deadline_timer_queue_top u_dut (.*);

  // predictor state
  logic [31:0] q_dl [NE];
  logic [15:0] q_client [NE];
  logic [2:0]  q_grp [NE];
  logic [5:0]  q_next [NE];
  logic [5:0]  q_prev [NE];
  logic        q_used [NE];
  logic [15:0] g_key [NG];
  logic [5:0]  g_head [NG];
  logic [5:0]  g_tail [NG];
  logic        g_used [NG];

  timer_rsp_t pending_rsp[$];
  int errors = 0;
  int live_count = 0;

  function automatic void link_tail(input int e, input int g);
    if (!g_used[g]) begin
      g_used[g] = 1; g_head[g] = 6'(e); g_tail[g] = 6'(e);
    end else begin
      q_next[g_tail[g]] = 6'(e); q_prev[e] = g_tail[g]; g_tail[g] = 6'(e);
    end
    q_grp[e] = 3'(g);
  endfunction

  function automatic void unlink(input int e);
    int g;
    logic hd, tl;
    g = int'(q_grp[e]);
    hd = int'(g_head[g]) == e;
    tl = int'(g_tail[g]) == e;
    if (hd && tl) begin
      g_used[g] = 0;
    end else if (hd) begin
      g_head[g] = q_next[e];
    end else if (tl) begin
      g_tail[g] = q_prev[e];
    end else begin
      q_next[q_prev[e]] = q_next[e];
      q_prev[q_next[e]] = q_prev[e];
    end
  endfunction

  function automatic timer_rsp_t apply_request(input timer_req_t r);
    timer_rsp_t o;
    int fe, mg, fg, e;
    logic found;
    logic [31:0] best;
    o = '0; fe = -1; mg = -1; fg = -1; found = 0; best = 0;
    if (r.kind == gdtq_pkg::KIND_ADD) begin
      for (int i = 0; i < NE; i++) if (!q_used[i] && fe < 0) fe = i;
      for (int i = 0; i < NG; i++) begin
        if (g_used[i] && g_key[i] == r.tmo && mg < 0) mg = i;
        if (!g_used[i] && fg < 0) fg = i;
      end
      if (fe < 0) o.status = gdtq_pkg::STATUS_ENTRY_FULL;
      else if (mg < 0 && fg < 0) o.status = gdtq_pkg::STATUS_GROUP_FULL;
      else begin
        if (mg < 0) begin
          mg = fg; g_key[mg] = r.tmo;
        end
        q_used[fe] = 1; q_client[fe] = r.client; q_dl[fe] = r.dl;
        link_tail(fe, mg);
        o.ehandle = 6'(fe); live_count++;
      end
    end else if (r.kind == gdtq_pkg::KIND_UPDATE || r.kind == gdtq_pkg::KIND_REMOVE) begin
      e = int'(r.handle);
      if (!q_used[e]) o.status = gdtq_pkg::STATUS_BAD_HANDLE;
      else begin
        o.ehandle = 6'(e);
        unlink(e);
        if (r.kind == gdtq_pkg::KIND_UPDATE) begin
          q_dl[e] = r.dl; link_tail(e, int'(q_grp[e]));
        end else begin
          q_used[e] = 0; live_count--;
        end
      end
    end else o.status = gdtq_pkg::STATUS_BAD_HANDLE;
    for (int i = 0; i < NG; i++)
      if (g_used[i] && (!found || q_dl[g_head[i]] < best)) begin
        found = 1; best = q_dl[g_head[i]]; o.mhandle = g_head[i];
      end
    o.mvalid = found;
    o.empty = !found;
    if (found) begin
      o.mclient = q_client[o.mhandle]; o.mdl = best;
    end else o.mhandle = 0;
    return o;
  endfunction

  // receiver: stalls on its own pattern; check every transfer
  int stall_mode = 0;
  always @(posedge clk) begin
    timer_rsp_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_status, out_entry_handle, out_min_valid, out_min_handle,
             out_min_client, out_min_deadline, out_is_empty};
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        want = pending_rsp.pop_front();
        if (got.status !== want.status || got.ehandle !== want.ehandle ||
            got.mvalid !== want.mvalid || got.mhandle !== want.mhandle ||
            got.mclient !== want.mclient || got.mdl !== want.mdl ||
            got.empty !== want.empty) begin
          errors++;
          $display("%0t: mismatch expected %h actual %h", $time, want, got);
        end
      end
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
    if ($urandom_range(0, 199) == 0) stall_mode <= int'($urandom_range(0, 2));
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  int burst_left = 0;

  task automatic send(input timer_req_t r, input logic has_typed, input timer_rsp_t t);
    timer_rsp_t p;
    if (burst_left == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1; in_kind <= r.kind; in_timeout_value <= r.tmo;
    in_client_id <= r.client; in_deadline <= r.dl; in_handle <= r.handle;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = apply_request(r);
    if (has_typed && p !== t) begin
      errors++;
      $display("%0t: predictor row expected %h actual %h", $time, t, p);
    end
    pending_rsp.insert(pending_rsp.size(), p);
  endtask

  // sender pauses until every expected result has come
  task automatic drain();
    in_valid <= 0;
    burst_left = 0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_live();
    int h;
    h = $urandom_range(0, NE - 1);
    for (int i = 0; i < NE; i++)
      if (q_used[(h + i) % NE]) return (h + i) % NE;
    return h;
  endfunction

  function automatic timer_req_t rand_fill();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[$bits(timer_req_t)-1:0];
  endfunction

  function automatic timer_req_t rand_req();
    timer_req_t r;
    int sel;
    r = rand_fill();
    sel = $urandom_range(0, 99);
    if (sel < 3) r.kind = KIND_BAD;
    else if (live_count < 20)
      r.kind = (sel < 70) ? gdtq_pkg::KIND_ADD :
               ((sel < 85) ? gdtq_pkg::KIND_UPDATE : gdtq_pkg::KIND_REMOVE);
    else if (live_count > 55)
      r.kind = (sel < 30) ? gdtq_pkg::KIND_ADD :
               ((sel < 50) ? gdtq_pkg::KIND_UPDATE : gdtq_pkg::KIND_REMOVE);
    else
      r.kind = (sel < 45) ? gdtq_pkg::KIND_ADD :
               ((sel < 72) ? gdtq_pkg::KIND_UPDATE : gdtq_pkg::KIND_REMOVE);
    if ($urandom_range(0, 9) != 0) r.tmo = 16'($urandom_range(0, 9) * 1000);
    if ($urandom_range(0, 3) == 0) r.dl = $urandom_range(0, 50);
    else if ($urandom_range(0, 9) == 0) r.dl = 32'hFFFF_FFF0 + $urandom_range(0, 15);
    if ((r.kind == gdtq_pkg::KIND_UPDATE || r.kind == gdtq_pkg::KIND_REMOVE) &&
        $urandom_range(0, 9) != 0)
      r.handle = 6'(pick_live());
    return r;
  endfunction

  timer_req_t dir_req [$];
  logic dir_typed [$];
  timer_rsp_t dir_rsp [$];

  task automatic row(input logic [1:0] k, input logic [15:0] tmo, input logic [15:0] cl,
                     input logic [31:0] dl, input logic [5:0] h, input logic typed,
                     input timer_rsp_t t);
    dir_req.insert(dir_req.size(), {k, tmo, cl, dl, h});
    dir_typed.insert(dir_typed.size(), typed);
    dir_rsp.insert(dir_rsp.size(), t);
  endtask

  initial begin
    timer_req_t r;
    for (int i = 0; i < NE; i++) q_used[i] = 0;
    for (int i = 0; i < NG; i++) g_used[i] = 0;
    // status, ehandle, mvalid, mhandle, mclient, mdl, empty
    row(gdtq_pkg::KIND_REMOVE, 0, 0, 0, 0, 1,
        {gdtq_pkg::STATUS_BAD_HANDLE, 6'd0, 1'b0, 6'd0, 16'd0, 32'd0, 1'b1});
    row(gdtq_pkg::KIND_UPDATE, 0, 0, 5, 63, 1,
        {gdtq_pkg::STATUS_BAD_HANDLE, 6'd0, 1'b0, 6'd0, 16'd0, 32'd0, 1'b1});
    row(KIND_BAD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 63, 1,
        {gdtq_pkg::STATUS_BAD_HANDLE, 6'd0, 1'b0, 6'd0, 16'd0, 32'd0, 1'b1});
    row(gdtq_pkg::KIND_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0, 1,
        {gdtq_pkg::STATUS_OK, 6'd0, 1'b1, 6'd0, 16'hFFFF, 32'hFFFF_FFFF, 1'b0});
    row(gdtq_pkg::KIND_ADD, 0, 0, 0, 0, 1,
        {gdtq_pkg::STATUS_OK, 6'd1, 1'b1, 6'd1, 16'd0, 32'd0, 1'b0});
    row(gdtq_pkg::KIND_ADD, 16'hFFFF, 7, 0, 0, 0, '0);
    row(gdtq_pkg::KIND_ADD, 5, 9, 0, 0, 0, '0);
    row(gdtq_pkg::KIND_UPDATE, 0, 0, 100, 0, 0, '0);
    row(gdtq_pkg::KIND_UPDATE, 0, 0, 3, 1, 0, '0);
    row(gdtq_pkg::KIND_REMOVE, 0, 0, 0, 2, 0, '0);
    row(gdtq_pkg::KIND_ADD, 6, 1, 3, 0, 0, '0);
    row(gdtq_pkg::KIND_ADD, 7, 2, 3, 0, 0, '0);
    row(gdtq_pkg::KIND_ADD, 8, 3, 3, 0, 0, '0);
    row(gdtq_pkg::KIND_ADD, 9, 4, 3, 0, 0, '0);
    row(gdtq_pkg::KIND_ADD, 10, 5, 3, 0, 0, '0);
    row(gdtq_pkg::KIND_ADD, 11, 6, 3, 0, 0, '0);
    row(gdtq_pkg::KIND_ADD, 12, 6, 3, 0, 0, '0);
    row(gdtq_pkg::KIND_REMOVE, 0, 0, 0, 0, 0, '0);
    row(gdtq_pkg::KIND_REMOVE, 0, 0, 0, 1, 0, '0);
    row(gdtq_pkg::KIND_REMOVE, 0, 0, 0, 3, 0, '0);
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (dir_req[i]) send(dir_req[i], dir_typed[i], dir_rsp[i]);
    // fill the entry table to exercise the full path, then drain some
    for (int i = 0; i < 70; i++) begin
      r = rand_fill();
      r.kind = gdtq_pkg::KIND_ADD; r.tmo = 16'($urandom_range(0, 3));
      send(r, 0, '0);
    end
    stall_mode = 1;
    for (int i = 0; i < 40; i++) begin
      r = rand_fill();
      r.kind = gdtq_pkg::KIND_REMOVE; r.handle = 6'(pick_live());
      send(r, 0, '0);
    end
    drain();
    for (int i = 0; i < 1650; i++) begin
      if (i == 800) drain();
      send(rand_req(), 0, '0);
    end
    drain();
    repeat (30) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
